[rtl/gos_pkg.sv]
// ----------------------------------------------------------------------------
// gos_pkg
// shared widths, register indexes, state encoding and control structs for the
// grain onset scheduler
// ----------------------------------------------------------------------------
package gos_pkg;

  // field widths
  localparam int RATE_W    = 18;
  localparam int MEV_W     = 7;
  localparam int BLEN_W    = 13;
  localparam int DENS_W    = 24;
  localparam int POS_W     = 17;
  localparam int FRAC_BITS = 16;

  // spacing = (sample_rate << SHIFT_W) / density
  localparam int SHIFT_W = FRAC_BITS + 8;
  localparam int QUO_W   = RATE_W + SHIFT_W;
  localparam int STEP_W  = $clog2(QUO_W);

  // onset accumulator, signed, FRAC_BITS fraction bits
  localparam int ACC_W = 46;
  localparam int CNT_W = 7;

  localparam int MAX_BLOCK  = 4096;
  localparam int MAX_EVENTS = 64;

  // port widths
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_TUSER_W = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 18;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_EVENTS  = 2'd1;

  localparam logic [RATE_W-1:0] SAMPLE_RATE_RST = 18'd48000;
  localparam logic [MEV_W-1:0]  MAX_EVENTS_RST  = 7'd64;

  localparam logic [QUO_W-1:0] ONE_SAMPLE = QUO_W'(1) << FRAC_BITS;

  localparam logic signed [ACC_W-1:0] CARRY_MAX = ACC_W'((64'sd1 <<< 43) - 64'sd1);
  localparam logic signed [ACC_W-1:0] CARRY_MIN = ACC_W'(-(64'sd65536 <<< FRAC_BITS));

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT,
    ST_ERR,
    ST_CARRY
  } gos_state_t;

  // sequencer to onset datapath
  typedef struct packed {
    logic clr_cnt;
    logic step;
    logic clr_acc;
    logic carry;
  } gos_ctrl_t;

  // onset datapath to sequencer
  typedef struct packed {
    logic go;
    logic last;
  } gos_stat_t;

endpackage

[rtl/grain_onset_scheduler.sv]
// ----------------------------------------------------------------------------
// grain_onset_scheduler
// schedules grain onsets for one announced audio block per input beat
// ----------------------------------------------------------------------------
// flow: the bit-serial spacing divide (42 steps) comes before the first result,
//   then one result per cycle while out_tready is high
// blocks: a new block is taken only in idle, once the last result of the
//   block is loaded; a block gives 1..64 results
// reset: synchronous active-low rst_n clears the carried offset, the sequencer
//   and the output beat, and restores sample_rate 48000 and max_events 64
// ----------------------------------------------------------------------------
module grain_onset_scheduler import gos_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  // input channel
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // block_length[12:0], density[36:13]
  // result channel
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // onset_position[16:0]
  output logic [OUT_TUSER_W-1:0] out_tuser,  // onset_valid[0], rate_error[1]
  output logic                   out_tlast,
  // configuration
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  // configuration registers
  logic [RATE_W-1:0] sample_rate_r;
  logic [MEV_W-1:0]  max_events_r;

  // sequencer
  gos_state_t state_r, state_nxt;

  // block captured at accept
  logic [BLEN_W-1:0] blen_r;
  logic              dens_zero_r;

  // output beat register
  logic                   out_tvalid_r, out_tvalid_nxt;
  logic [POS_W-1:0]       out_pos_r;
  logic                   out_valid_r;
  logic                   out_err_r;
  logic                   out_last_r;

  // result being loaded
  logic             load_out;
  logic [POS_W-1:0] res_pos;
  logic             res_valid;
  logic             res_err;
  logic             res_last;

  logic              accept;
  logic              slot_free;
  logic [BLEN_W-1:0] in_blen;
  logic [DENS_W-1:0] in_dens;
  logic [BLEN_W-1:0] blen_sat;
  logic [CNT_W-1:0]  cap;

  logic [QUO_W-1:0] spacing;
  logic             div_done;
  logic             rate_err;

  gos_ctrl_t        ctrl;
  gos_stat_t        stat;
  logic [POS_W-1:0] position;

  // input unpacking and block length saturation
  assign in_blen  = in_tdata[BLEN_W-1:0];
  assign in_dens  = in_tdata[BLEN_W +: DENS_W];
  assign blen_sat = (in_blen > BLEN_W'(MAX_BLOCK)) ? BLEN_W'(MAX_BLOCK) : in_blen;

  // event cap is the lesser of the register and the hard limit
  assign cap = (max_events_r > MEV_W'(MAX_EVENTS)) ? CNT_W'(MAX_EVENTS) : CNT_W'(max_events_r);

  assign accept    = in_tvalid && in_tready;
  // a result may be loaded when the output register is empty or being drained
  assign slot_free = !out_tvalid_r || out_tready;

  // spacing of at most one sample, or no density, is a rate error
  assign rate_err = dens_zero_r || (spacing <= ONE_SAMPLE);

  // configuration writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_rate_r <= SAMPLE_RATE_RST;
      max_events_r  <= MAX_EVENTS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SAMPLE_RATE: sample_rate_r <= cfg_wdata[RATE_W-1:0];
        CFG_MAX_EVENTS:  max_events_r  <= cfg_wdata[MEV_W-1:0];
        default: ;
      endcase
    end
  end

  // capture the block on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      blen_r      <= blen_sat;
      dens_zero_r <= (in_dens == '0);
    end
  end

  // spacing divider, started straight from the accepted beat
  gos_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept),
    .dividend ({sample_rate_r, {SHIFT_W{1'b0}}}),
    .divisor  (in_dens),
    .quotient (spacing),
    .done     (div_done)
  );

  // onset accumulator and carried offset
  gos_onset_gen u_gen (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .blen     (blen_r),
    .spacing  (spacing),
    .cap      (cap),
    .stat     (stat),
    .position (position)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) state_nxt = rate_err ? ST_ERR : ST_EMIT;
      end
      ST_EMIT: begin
        // stop on the marker or on the final onset
        if (slot_free && (!stat.go || stat.last)) state_nxt = ST_CARRY;
      end
      ST_ERR: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      ST_CARRY: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready    = 1'b0;
    ctrl         = '0;
    ctrl.clr_cnt = accept;
    load_out     = 1'b0;
    res_pos      = '0;
    res_valid    = 1'b0;
    res_err      = 1'b0;
    res_last     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
      end
      ST_DIV: ;
      ST_EMIT: begin
        if (slot_free) begin
          load_out = 1'b1;
          if (stat.go) begin
            // onset at the floor of the current position
            res_pos   = position;
            res_valid = 1'b1;
            res_last  = stat.last;
            ctrl.step = 1'b1;
          end else begin
            // no onset inside the block: lone marker
            res_last = 1'b1;
          end
        end
      end
      ST_ERR: begin
        if (slot_free) begin
          load_out     = 1'b1;
          res_err      = 1'b1;
          res_last     = 1'b1;
          ctrl.clr_acc = 1'b1;
        end
      end
      ST_CARRY: begin
        // offset minus block length, saturated, goes on to the next block
        ctrl.carry = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // output beat register
  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    priority if (load_out) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_pos_r   <= res_pos;
      out_valid_r <= res_valid;
      out_err_r   <= res_err;
      out_last_r  <= res_last;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_TDATA_W-POS_W){1'b0}}, out_pos_r};
  assign out_tuser  = {out_err_r, out_valid_r};
  assign out_tlast  = out_last_r;

endmodule

[rtl/gos_divider.sv]
// ----------------------------------------------------------------------------
// gos_divider
// radix-2 restoring divider, one quotient bit per cycle shifted into the
// dividend register
// ----------------------------------------------------------------------------
module gos_divider import gos_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [QUO_W-1:0]  dividend,
  input  logic [DENS_W-1:0] divisor,
  output logic [QUO_W-1:0]  quotient,
  output logic              done
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [DENS_W-1:0] rem_r, rem_nxt;
  logic [QUO_W-1:0]  quo_r, quo_nxt;
  logic [DENS_W-1:0] dsr_r, dsr_nxt;

  logic [DENS_W:0]   shifted;
  logic [DENS_W+1:0] trial;
  logic              fits;

  assign shifted = {rem_r, quo_r[QUO_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dsr_r};
  assign fits    = ~trial[DENS_W+1];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[QUO_W-2:0], fits};
      rem_nxt = fits ? trial[DENS_W-1:0] : shifted[DENS_W-1:0];
      cnt_nxt = cnt_r + STEP_W'(1);
      if (cnt_r == STEP_W'(QUO_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

[rtl/gos_onset_gen.sv]
// ----------------------------------------------------------------------------
// gos_onset_gen
// onset accumulator, event counter and carried offset update
// ----------------------------------------------------------------------------
module gos_onset_gen import gos_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  gos_ctrl_t         ctrl,
  input  logic [BLEN_W-1:0] blen,
  input  logic [QUO_W-1:0]  spacing,
  input  logic [CNT_W-1:0]  cap,
  output gos_stat_t         stat,
  output logic [POS_W-1:0]  position
);

  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;

  logic signed [ACC_W-1:0] end_s;
  logic signed [ACC_W-1:0] next_s;
  logic signed [ACC_W-1:0] diff_s;
  logic signed [ACC_W-1:0] carry_s;

  assign end_s  = signed'({{(ACC_W-BLEN_W-FRAC_BITS){1'b0}}, blen, {FRAC_BITS{1'b0}}});
  assign next_s = acc_r + signed'({{(ACC_W-QUO_W){1'b0}}, spacing});
  assign diff_s = acc_r - end_s;

  // saturate the carry into its allowed range
  always_comb begin
    priority if (diff_s > CARRY_MAX) begin
      carry_s = CARRY_MAX;
    end else if (diff_s < CARRY_MIN) begin
      carry_s = CARRY_MIN;
    end else begin
      carry_s = diff_s;
    end
  end

  assign stat.go   = (acc_r < end_s) && (cnt_r < cap);
  assign stat.last = (next_s >= end_s) || ((cnt_r + CNT_W'(1)) == cap);
  // floor toward minus infinity is the arithmetic shift
  assign position  = acc_r[FRAC_BITS +: POS_W];

  always_comb begin
    acc_nxt = acc_r;
    priority if (ctrl.clr_acc) begin
      acc_nxt = '0;
    end else if (ctrl.carry) begin
      acc_nxt = carry_s;
    end else if (ctrl.step) begin
      acc_nxt = next_s;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    priority if (ctrl.clr_cnt) begin
      cnt_nxt = '0;
    end else if (ctrl.step) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      cnt_r <= '0;
    end else begin
      acc_r <= acc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
